/* hdl/nstl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package nstl_pkg;
   localparam int TableDepth = 64;
   localparam int RowBits    = $clog2(TableDepth);
   localparam int CountBits  = $clog2(TableDepth + 1);
   localparam int DimBits    = 16;
   localparam int SqBits     = 2 * DimBits + 2;
   localparam int RootBits   = DimBits + 1;
   localparam int RootSteps  = SqBits / 2;

   typedef enum logic [1:0] {
      MODE_CLEAR = 2'd0,
      MODE_LOAD  = 2'd1,
      MODE_QUERY = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef struct packed {
      logic [15:0] dim_m;
      logic [15:0] dim_n;
      logic [15:0] dim_k;
      logic [15:0] dim_b;
   } shape_type;

   typedef struct packed {
      logic [7:0] tile_m;
      logic [7:0] tile_n;
      logic [7:0] tile_k;
      logic       image_flag;
   } tuning_type;

   typedef struct packed {
      logic [1:0]  mode;
      shape_type   shape;
      tuning_type  tuning;
      logic        left_transposed;
      logic        right_transposed;
   } req_type;

   typedef struct packed {
      logic              valid_res;
      logic [5:0]        best_row;
      logic [16:0]       best_distance;
      tuning_type        tuning;
      logic              out_left_transposed;
      logic              out_right_transposed;
   } rsp_type;

   typedef struct packed {
      logic               capture;
      logic               clear;
      logic               load;
      logic               read_row;
      logic               dist_start;
      logic               root_start;
      logic               root_step;
      logic               compare;
      logic               first;
      logic               fetch_best;
      logic               finish;
      logic [RowBits-1:0] row;
   } cmd_type;

   typedef struct packed {
      logic                 full;
      logic                 empty;
      logic [CountBits-1:0] count;
   } sts_type;
endpackage
`default_nettype wire

/* hdl/nstl_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface nstl_req_if;
   logic             valid;
   logic             ready;
   nstl_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface nstl_rsp_if;
   logic             valid;
   logic             ready;
   nstl_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* hdl/nearest_shape_table_lookup_top.sv */
// Nearest-shape table lookup.
// req channel: one item per clear, load or query (mode field). Loads append a
// row (shape plus tuning) to a 64-row table; loads into a full table are dropped.
// A query scans every stored row: per row one read, one squared-distance step,
// one root start and 17 square-root steps, then a compare.
// rsp channel: one item per query only. An empty table yields an all-zero item.
// Order: clear/load are decoded and return to idle; a query is decoded, scans the
// rows, fetches the best row's tuning and finishes; an empty-table query skips to finish.
// Throughput: one item at a time; req_ready is high only while the block is idle.
// The square-root unit is the shared iterative loop that sets the row rate.
// Reset (synchronous) empties the table and drops any pending result.
// When the receiver stalls, the result holds in the output register and no new
// item is taken until it is delivered.
`timescale 1ns / 1ps
`default_nettype none
module nearest_shape_table_lookup_top (
   input wire logic clock,
   input wire logic reset,
   nstl_req_if.sink   req,
   nstl_rsp_if.source rsp
);
   nstl_pkg::cmd_type cmd;
   nstl_pkg::sts_type sts;

   nstl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_mode  (req.payload.mode),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   nstl_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .req_in  (req.payload),
      .cmd     (cmd),
      .sts     (sts),
      .rsp_out (rsp.payload)
   );
endmodule
`default_nettype wire

/* hdl/nstl_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module nstl_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire nstl_pkg::req_type req_in,
   input  wire nstl_pkg::cmd_type cmd,
   output nstl_pkg::sts_type      sts,
   output nstl_pkg::rsp_type      rsp_out
);
   localparam int RB = nstl_pkg::RowBits;
   localparam int CB = nstl_pkg::CountBits;
   localparam int SB = nstl_pkg::SqBits;
   localparam int QB = nstl_pkg::RootBits;
   localparam int DB = nstl_pkg::DimBits;

   nstl_pkg::shape_type  shape_mem  [nstl_pkg::TableDepth];
   nstl_pkg::tuning_type tuning_mem [nstl_pkg::TableDepth];

   nstl_pkg::req_type    query_ff;
   nstl_pkg::shape_type  row_shape_ff;
   nstl_pkg::tuning_type tuning_rd_ff;
   logic [CB-1:0]        count_ff, count_in;
   logic [RB-1:0]        row_ff;
   logic [SB-1:0]        acc_ff, rem_ff, rem_in;
   logic [SB-1:0]        res_ff, res_in, bit_ff;
   logic [QB-1:0]        best_d_ff;
   logic [RB-1:0]        best_row_ff;
   nstl_pkg::rsp_type    rsp_ff;

   function automatic logic [SB-1:0] sq(input logic [DB-1:0] a, input logic [DB-1:0] b);
      logic [DB-1:0] d;
      logic [SB-1:0] w;
      d = (a >= b) ? a - b : b - a;
      w = SB'(d);
      return w * w;
   endfunction

   assign sts.count = count_ff;
   assign sts.full  = (count_ff == CB'(nstl_pkg::TableDepth));
   assign sts.empty = (count_ff == '0);
   assign rsp_out   = rsp_ff;

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.load && !sts.full) begin
         count_in = count_ff + CB'(1);
      end
   end

   always_comb begin
      rem_in = rem_ff;
      res_in = res_ff >> 1;
      if (rem_ff >= res_ff + bit_ff) begin
         rem_in = rem_ff - (res_ff + bit_ff);
         res_in = (res_ff >> 1) + bit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      if (cmd.capture) begin
         query_ff <= req_in;
      end
      if (cmd.load && !sts.full) begin
         shape_mem[count_ff[RB-1:0]]  <= query_ff.shape;
         tuning_mem[count_ff[RB-1:0]] <= query_ff.tuning;
      end
      if (cmd.read_row) begin
         row_shape_ff <= shape_mem[cmd.row];
         row_ff       <= cmd.row;
      end
      if (cmd.fetch_best) begin
         tuning_rd_ff <= tuning_mem[best_row_ff];
      end
      if (cmd.dist_start) begin
         acc_ff <= sq(query_ff.shape.dim_m, row_shape_ff.dim_m)
                 + sq(query_ff.shape.dim_n, row_shape_ff.dim_n)
                 + sq(query_ff.shape.dim_k, row_shape_ff.dim_k)
                 + sq(query_ff.shape.dim_b, row_shape_ff.dim_b);
      end
      if (cmd.root_start) begin
         rem_ff <= acc_ff;
         res_ff <= '0;
         bit_ff <= SB'(1) << (SB - 2);
      end else if (cmd.root_step) begin
         rem_ff <= rem_in;
         res_ff <= res_in;
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.compare && (cmd.first || res_ff[QB-1:0] < best_d_ff)) begin
         best_d_ff   <= res_ff[QB-1:0];
         best_row_ff <= row_ff;
      end
      if (cmd.finish) begin
         if (sts.empty) begin
            rsp_ff <= '0;
         end else begin
            rsp_ff.valid_res            <= 1'b1;
            rsp_ff.best_row             <= 6'(best_row_ff);
            rsp_ff.best_distance        <= best_d_ff;
            rsp_ff.tuning               <= tuning_rd_ff;
            rsp_ff.out_left_transposed  <= query_ff.left_transposed;
            rsp_ff.out_right_transposed <= query_ff.right_transposed;
         end
      end
   end
endmodule
`default_nettype wire

/* hdl/nstl_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module nstl_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [1:0]        req_mode,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire nstl_pkg::sts_type sts,
   output nstl_pkg::cmd_type      cmd
);
   localparam int RB = nstl_pkg::RowBits;
   localparam int KB = $clog2(nstl_pkg::RootSteps + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_READ, S_DIST, S_RSTART, S_ROOT, S_CMP, S_FETCH,
      S_FIN, S_OUT
   } state_type;

   state_type        state_ff, state_in;
   logic [1:0]       mode_ff, mode_in;
   logic [RB-1:0]    row_ff, row_in;
   logic [KB-1:0]    step_ff, step_in;
   logic             first_ff, first_in;
   logic             rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      row_in       = row_ff;
      step_in      = step_ff;
      first_in     = first_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.row      = row_ff;
      cmd.first    = first_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               mode_in     = req_mode;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            row_in   = '0;
            first_in = 1'b1;
            state_in = S_IDLE;
            unique case (mode_ff)
               nstl_pkg::MODE_CLEAR: cmd.clear = 1'b1;
               nstl_pkg::MODE_LOAD:  cmd.load  = 1'b1;
               nstl_pkg::MODE_QUERY: state_in  = sts.empty ? S_FIN : S_READ;
               default:              state_in  = S_IDLE;
            endcase
         end
         S_READ: begin
            cmd.read_row = 1'b1;
            state_in     = S_DIST;
         end
         S_DIST: begin
            cmd.dist_start = 1'b1;
            state_in       = S_RSTART;
         end
         S_RSTART: begin
            cmd.root_start = 1'b1;
            step_in        = '0;
            state_in       = S_ROOT;
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            step_in       = step_ff + KB'(1);
            if (step_ff == KB'(nstl_pkg::RootSteps - 1)) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            cmd.compare = 1'b1;
            first_in    = 1'b0;
            if ({1'b0, row_ff} + 1'b1 == sts.count) begin
               state_in = S_FETCH;
            end else begin
               row_in   = row_ff + RB'(1);
               state_in = S_READ;
            end
         end
         S_FETCH: begin
            cmd.fetch_best = 1'b1;
            state_in       = S_FIN;
         end
         S_FIN: begin
            cmd.finish   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= '0;
         row_ff       <= '0;
         step_ff      <= '0;
         first_ff     <= 1'b1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         row_ff       <= row_in;
         step_ff      <= step_in;
         first_ff     <= first_in;
      end
   end
endmodule
`default_nettype wire

/* hdl/nstl_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module nstl_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire nstl_pkg::rsp_type rsp_payload
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp item changed under stall");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while result pending");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.valid_res |-> rsp_payload == '0)
      else $error("empty result not zero");
   a_one_cycle_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after accept");
endmodule

bind nearest_shape_table_lookup_top nstl_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_payload (rsp.payload)
);
`default_nettype wire

/* bench/nearest_shape_table_lookup_top_tb.sv */
`timescale 1ns / 1ps
module nearest_shape_table_lookup_top_tb;

   class lookup_scoreboard;
      nstl_pkg::shape_type  shapes[nstl_pkg::TableDepth];
      nstl_pkg::tuning_type tunings[nstl_pkg::TableDepth];
      int         rows;
      nstl_pkg::rsp_type    pending[$];
      int         errors;

      function void note_request(nstl_pkg::req_type r);
         int unsigned best;
         longint unsigned best_d;
         longint unsigned acc;
         longint unsigned d;
         longint unsigned sq;
         longint unsigned bit_v;
         longint unsigned res;
         nstl_pkg::rsp_type o;
         nstl_pkg::shape_type s;
         case (nstl_pkg::mode_type'(r.mode))
            nstl_pkg::MODE_CLEAR: rows = 0;
            nstl_pkg::MODE_LOAD: begin
               if (rows < nstl_pkg::TableDepth) begin
                  shapes[rows] = r.shape;
                  tunings[rows] = r.tuning;
                  rows++;
               end
            end
            nstl_pkg::MODE_QUERY: begin
               o = '0;
               if (rows > 0) begin
                  best = 0;
                  best_d = 0;
                  for (int i = 0; i < rows; i++) begin
                     s = shapes[i];
                     acc = 0;
                     d = (r.shape.dim_m > s.dim_m) ? r.shape.dim_m - s.dim_m
                                                   : s.dim_m - r.shape.dim_m;
                     acc += d * d;
                     d = (r.shape.dim_n > s.dim_n) ? r.shape.dim_n - s.dim_n
                                                   : s.dim_n - r.shape.dim_n;
                     acc += d * d;
                     d = (r.shape.dim_k > s.dim_k) ? r.shape.dim_k - s.dim_k
                                                   : s.dim_k - r.shape.dim_k;
                     acc += d * d;
                     d = (r.shape.dim_b > s.dim_b) ? r.shape.dim_b - s.dim_b
                                                   : s.dim_b - r.shape.dim_b;
                     acc += d * d;
                     sq = acc;
                     res = 0;
                     bit_v = 64'd1 << 62;
                     while (bit_v > sq) bit_v >>= 2;
                     while (bit_v != 0) begin
                        if (sq >= res + bit_v) begin
                           sq -= res + bit_v;
                           res = (res >> 1) + bit_v;
                        end else begin
                           res >>= 1;
                        end
                        bit_v >>= 2;
                     end
                     if (i == 0 || res < best_d) begin
                        best_d = res;
                        best = i;
                     end
                  end
                  o.valid_res = 1'b1;
                  o.best_row = best[5:0];
                  o.best_distance = best_d[16:0];
                  o.tuning = tunings[best];
                  o.out_left_transposed = r.left_transposed;
                  o.out_right_transposed = r.right_transposed;
               end
               pending.push_back(o);
            end
            default: ;
         endcase
      endfunction

      function void check_result(nstl_pkg::rsp_type a);
         nstl_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t unexpected item %h", $time, a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.valid_res !== e.valid_res) begin
            $display("%0t valid_res exp %0d got %0d", $time, e.valid_res, a.valid_res);
            errors++;
         end
         if (a.best_row !== e.best_row) begin
            $display("%0t best_row exp %0d got %0d", $time, e.best_row, a.best_row);
            errors++;
         end
         if (a.best_distance !== e.best_distance) begin
            $display("%0t best_distance exp %0d got %0d", $time, e.best_distance,
                     a.best_distance);
            errors++;
         end
         if (a.tuning !== e.tuning) begin
            $display("%0t tuning exp %h got %h", $time, e.tuning, a.tuning);
            errors++;
         end
         if (a.out_left_transposed !== e.out_left_transposed) begin
            $display("%0t left exp %0d got %0d", $time, e.out_left_transposed,
                     a.out_left_transposed);
            errors++;
         end
         if (a.out_right_transposed !== e.out_right_transposed) begin
            $display("%0t right exp %0d got %0d", $time, e.out_right_transposed,
                     a.out_right_transposed);
            errors++;
         end
      endfunction
   endclass

   localparam int WatchLimit = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   idle_cycles = 0;
   bit   stim_done = 1'b0;
   lookup_scoreboard board;

   nstl_req_if req_ch ();
   nstl_rsp_if rsp_ch ();

   nearest_shape_table_lookup_top dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      board = new();
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) board.note_request(req_ch.payload);
         if (rsp_ch.valid && rsp_ch.ready) board.check_result(rsp_ch.payload);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchLimit) begin
            $display("nearest_shape_table_lookup_top_tb: FAIL");
            $finish;
         end
      end
   end

   initial begin : rsp_side
      int waits;
      int calm;
      calm = 0;
      @(negedge clock);
      forever begin
         waits = (calm > 0) ? 0 : $urandom_range(0, 3);
         if (calm > 0) calm--;
         else if ($urandom_range(0, 30) == 0) calm = 40;
         if (waits > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (waits) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   bit steady = 1'b0;

   task automatic send_item(nstl_pkg::req_type r);
      int waits;
      waits = steady ? 0 : $urandom_range(0, 3);
      if (waits > 0) begin
         req_ch.valid <= 1'b0;
         repeat (waits) @(negedge clock);
      end
      req_ch.payload <= r;
      req_ch.valid <= 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   function automatic nstl_pkg::shape_type random_shape(bit near);
      nstl_pkg::shape_type s;
      s.dim_m = near ? 16'($urandom_range(0, 40)) : 16'($urandom);
      s.dim_n = near ? 16'($urandom_range(0, 40)) : 16'($urandom);
      s.dim_k = near ? 16'($urandom_range(0, 40)) : 16'($urandom);
      s.dim_b = near ? 16'($urandom_range(0, 40)) : 16'($urandom);
      if (!near && $urandom_range(0, 7) == 0) s = '1;
      if (!near && $urandom_range(0, 7) == 0) s = '0;
      return s;
   endfunction

   function automatic nstl_pkg::req_type make_item(nstl_pkg::mode_type m,
                                                   nstl_pkg::shape_type s);
      nstl_pkg::req_type r;
      r.mode = m;
      r.shape = s;
      r.tuning.tile_m = 8'($urandom);
      r.tuning.tile_n = 8'($urandom);
      r.tuning.tile_k = 8'($urandom);
      r.tuning.image_flag = 1'($urandom);
      r.left_transposed = 1'($urandom);
      r.right_transposed = 1'($urandom);
      return r;
   endfunction

   initial begin : req_side
      nstl_pkg::req_type r;
      int rows_now;
      bit near;
      nstl_pkg::mode_type m;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_item(make_item(nstl_pkg::MODE_QUERY, '1));
      send_item(make_item(nstl_pkg::MODE_LOAD, '0));
      send_item(make_item(nstl_pkg::MODE_LOAD, '1));
      send_item(make_item(nstl_pkg::MODE_LOAD, '0));
      send_item(make_item(nstl_pkg::MODE_QUERY, '0));
      send_item(make_item(nstl_pkg::MODE_QUERY, '1));
      send_item(make_item(nstl_pkg::MODE_QUERY, 64'h0000_FFFF_0000_FFFF));
      send_item(make_item(nstl_pkg::MODE_NONE, '1));
      send_item(make_item(nstl_pkg::MODE_QUERY, 64'h8000_8000_8000_8000));
      send_item(make_item(nstl_pkg::MODE_CLEAR, '0));
      send_item(make_item(nstl_pkg::MODE_QUERY, 64'h1234_5678_9ABC_DEF0));
      for (int i = 0; i < 66; i++) begin
         steady = 1'b1;
         send_item(make_item(nstl_pkg::MODE_LOAD, random_shape(1'b1)));
      end
      steady = 1'b0;
      send_item(make_item(nstl_pkg::MODE_QUERY, random_shape(1'b1)));
      send_item(make_item(nstl_pkg::MODE_QUERY, '1));
      drain();
      send_item(make_item(nstl_pkg::MODE_CLEAR, '0));
      rows_now = 0;
      for (int i = 0; i < 1000; i++) begin
         near = $urandom_range(0, 1);
         case ($urandom_range(0, 19))
            0: m = nstl_pkg::MODE_CLEAR;
            1: m = nstl_pkg::MODE_NONE;
            2, 3, 4, 5, 6, 7, 8: m = nstl_pkg::MODE_QUERY;
            default: m = nstl_pkg::MODE_LOAD;
         endcase
         if (m == nstl_pkg::MODE_LOAD && rows_now > 12 && $urandom_range(0, 3) != 0)
            m = nstl_pkg::MODE_QUERY;
         if (m == nstl_pkg::MODE_CLEAR) rows_now = 0;
         if (m == nstl_pkg::MODE_LOAD) rows_now++;
         steady = (i % 200) > 170;
         r = make_item(m, random_shape(near));
         send_item(r);
         if (i == 500) drain();
      end
      drain();
      stim_done = 1'b1;
   end

   initial begin
      wait (stim_done);
      repeat (1500) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("nearest_shape_table_lookup_top_tb: PASS");
      else
         $display("nearest_shape_table_lookup_top_tb: FAIL");
      $finish;
   end
endmodule
